/* hw/rtl/nfd_pkg.sv */
// shared types and codes of the nfc frame deframer
package nfd_pkg;

  localparam logic [7:0]  DIR_BYTE         = 8'hD5;
  localparam logic [7:0]  START_HI         = 8'hFF;
  localparam logic [7:0]  START_LO         = 8'h00;
  localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd255;
  localparam logic [15:0] MIN_FRAME_LENGTH = 16'd2;

  // input command codes
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_LCS      = 3'd1,
    ST_BAD_DIR      = 3'd2,
    ST_SHORT_LENGTH = 3'd3,
    ST_OVER_LENGTH  = 3'd4,
    ST_BAD_DCS      = 3'd5,
    ST_BAD_POST     = 3'd6,
    ST_TIMEOUT      = 3'd7
  } status_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  response_code;
    logic [15:0] payload_length;
    logic        is_last;
  } out_item_t;

  // handshake between the pipeline stages
  typedef struct packed {
    logic advance;
    logic space;
  } pipe_ctl_t;

endpackage

/* hw/rtl/nfc_frame_deframer_unit.sv */
// top level of the nfc frame deframer
//
//  channel | direction | handshake            | content
//  in_     | input     | in_valid / in_ready   | in_item: cmd, rx_byte
//  out_    | output    | out_valid / out_ready | out_item: payload byte or status
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_data: max_payload
//
// one item per cycle unless the result register stalls; out_valid rises at the edge that
// takes the held item from the input register through the parse step into the result register
// items that give no result pass through the parser without using the result register
// a stalled result register holds the parser and, once the input register is full, in_ready
// reset (rst_n low, synchronous) returns to start code hunting, max_payload to 255
// cfg_ready is always high
module nfc_frame_deframer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nfd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output nfd_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import nfd_pkg::*;

  logic        hold_valid;
  in_item_t    hold_item;
  pipe_ctl_t   ctl;
  logic        space;
  logic        res_valid;
  out_item_t   res;
  logic [15:0] max_payload_r;

  assign cfg_ready   = 1'b1;
  assign ctl.space   = space;
  assign ctl.advance = hold_valid && space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_data;
    end
  end

  nfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .ctl        (ctl),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  nfd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (ctl.advance),
    .item        (hold_item),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  nfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctl.advance && res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* hw/rtl/nfd_in_reg.sv */
// input register stage of the nfc frame deframer
module nfd_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nfd_pkg::in_item_t  in_item,
  input  nfd_pkg::pipe_ctl_t ctl,
  output logic               hold_valid,
  output nfd_pkg::in_item_t  hold_item
);
  import nfd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // the held item moves on in the same cycle a new one can enter
  assign in_ready   = !valid_r || ctl.space;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (ctl.advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* hw/rtl/nfd_core.sv */
// frame parser: phase machine, length and checksum tracking, result forming
module nfd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  nfd_pkg::in_item_t  item,
  input  logic [15:0]        max_payload,
  output logic               res_valid,
  output nfd_pkg::out_item_t res
);
  import nfd_pkg::*;

  typedef enum logic [10:0] {
    PH_HUNT = 11'b000_0000_0001,
    PH_LEN  = 11'b000_0000_0010,
    PH_LCS  = 11'b000_0000_0100,
    PH_EHI  = 11'b000_0000_1000,
    PH_ELO  = 11'b000_0001_0000,
    PH_ELCS = 11'b000_0010_0000,
    PH_DIR  = 11'b000_0100_0000,
    PH_CODE = 11'b000_1000_0000,
    PH_DATA = 11'b001_0000_0000,
    PH_DCS  = 11'b010_0000_0000,
    PH_POST = 11'b100_0000_0000
  } phase_t;

  phase_t      phase_r,  phase_nxt;
  logic [7:0]  prev_r,   prev_nxt;
  logic [15:0] flen_r,   flen_nxt;
  logic [15:0] left_r,   left_nxt;
  logic [7:0]  dsum_r,   dsum_nxt;
  logic [7:0]  hsum_r,   hsum_nxt;
  logic [7:0]  resp_r,   resp_nxt;

  logic [7:0]  b;
  logic [15:0] pcount;
  logic [7:0]  hsum_add;
  logic [7:0]  dsum_add;
  logic        emit;
  logic        fin;
  status_t     fin_st;

  assign b        = item.rx_byte;
  assign pcount   = flen_r - MIN_FRAME_LENGTH;
  assign hsum_add = hsum_r + b;
  assign dsum_add = dsum_r + b;

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    flen_nxt  = flen_r;
    left_nxt  = left_r;
    dsum_nxt  = dsum_r;
    hsum_nxt  = hsum_r;
    resp_nxt  = resp_r;
    emit      = 1'b0;
    fin       = 1'b0;
    fin_st    = ST_OK;

    if (item.cmd == CMD_TIMEOUT) begin
      fin    = 1'b1;
      fin_st = ST_TIMEOUT;
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          if (prev_r == START_LO && b == START_HI) begin
            prev_nxt  = 8'hFF;
            resp_nxt  = 8'h00;
            phase_nxt = PH_LEN;
          end else begin
            prev_nxt = b;
          end
        end
        PH_LEN: begin
          hsum_nxt  = b;
          phase_nxt = PH_LCS;
        end
        PH_LCS: begin
          // LEN and LCS both FF mark the extended length form
          if (hsum_r == 8'hFF && b == 8'hFF) begin
            phase_nxt = PH_EHI;
          end else if (hsum_add != 8'h00) begin
            fin    = 1'b1;
            fin_st = ST_BAD_LCS;
          end else begin
            flen_nxt  = {8'h00, hsum_r};
            phase_nxt = PH_DIR;
          end
        end
        PH_EHI: begin
          hsum_nxt  = b;
          flen_nxt  = {b, 8'h00};
          phase_nxt = PH_ELO;
        end
        PH_ELO: begin
          hsum_nxt  = hsum_add;
          flen_nxt  = {flen_r[15:8], b};
          phase_nxt = PH_ELCS;
        end
        PH_ELCS: begin
          if (hsum_add != 8'h00) begin
            fin    = 1'b1;
            fin_st = ST_BAD_LCS;
          end else begin
            phase_nxt = PH_DIR;
          end
        end
        PH_DIR: begin
          if (b != DIR_BYTE) begin
            fin    = 1'b1;
            fin_st = ST_BAD_DIR;
          end else begin
            phase_nxt = PH_CODE;
          end
        end
        PH_CODE: begin
          resp_nxt = b;
          dsum_nxt = DIR_BYTE + b;
          if (flen_r < MIN_FRAME_LENGTH) begin
            fin    = 1'b1;
            fin_st = ST_SHORT_LENGTH;
          end else if (pcount > max_payload) begin
            fin    = 1'b1;
            fin_st = ST_OVER_LENGTH;
          end else begin
            left_nxt  = pcount;
            phase_nxt = (pcount != 16'd0) ? PH_DATA : PH_DCS;
          end
        end
        PH_DATA: begin
          dsum_nxt = dsum_add;
          left_nxt = left_r - 16'd1;
          emit     = 1'b1;
          if (left_r == 16'd1) begin
            phase_nxt = PH_DCS;
          end
        end
        PH_DCS: begin
          dsum_nxt  = dsum_add;
          phase_nxt = PH_POST;
        end
        PH_POST: begin
          fin = 1'b1;
          // checksum error wins over a bad postamble
          if (dsum_r != 8'h00) begin
            fin_st = ST_BAD_DCS;
          end else if (b != 8'h00) begin
            fin_st = ST_BAD_POST;
          end else begin
            fin_st = ST_OK;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          prev_nxt  = 8'hFF;
        end
      endcase
    end

    if (fin) begin
      phase_nxt = PH_HUNT;
      prev_nxt  = 8'hFF;
    end
  end

  always_comb begin
    res_valid = emit || fin;
    if (fin) begin
      res.kind           = KIND_STATUS;
      res.payload_byte   = 8'h00;
      res.status         = fin_st;
      res.response_code  = (fin_st == ST_OK) ? resp_r : 8'h00;
      res.payload_length = (fin_st == ST_OK) ? pcount : 16'd0;
      res.is_last        = 1'b1;
    end else begin
      res.kind           = KIND_DATA;
      res.payload_byte   = b;
      res.status         = ST_OK;
      res.response_code  = resp_r;
      res.payload_length = pcount;
      res.is_last        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      prev_r  <= 8'hFF;
      flen_r  <= 16'd0;
      left_r  <= 16'd0;
      dsum_r  <= 8'h00;
      hsum_r  <= 8'h00;
      resp_r  <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      flen_r  <= flen_nxt;
      left_r  <= left_nxt;
      dsum_r  <= dsum_nxt;
      hsum_r  <= hsum_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

/* hw/rtl/nfd_out_reg.sv */
// result register stage of the nfc frame deframer
module nfd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  nfd_pkg::out_item_t res,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output nfd_pkg::out_item_t out_item
);
  import nfd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

endmodule

/* hw/rtl/nfd_checker.sv */
// port level checks of the nfc frame deframer and their bind
module nfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input nfd_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input nfd_pkg::out_item_t out_item,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [15:0]        cfg_data
);
  import nfd_pkg::*;

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // payload items never carry an end mark or a status
  a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_DATA |-> !out_item.is_last && out_item.status == ST_OK)
    else $error("payload item with end mark or status");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_STATUS |-> out_item.is_last && out_item.payload_byte == 8'h00)
    else $error("status item without end mark");

  // error status items clear the frame fields
  a_error_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK
      |-> out_item.response_code == 8'h00 && out_item.payload_length == 16'd0)
    else $error("error status carries frame fields");

endmodule

bind nfc_frame_deframer_unit nfd_checker u_nfd_checker (.*);

/* bench/nfd_frame_checker.sv */
// result checker for the nfc frame deframer: tracks the frame parser and compares every result
`timescale 1ns / 1ps
module nfd_frame_checker
  import nfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          error_count,
  output int          pending_count
);

  typedef enum logic [3:0] {
    RX_HUNT,
    RX_LEN,
    RX_LCS,
    RX_EXT_HI,
    RX_EXT_LO,
    RX_EXT_LCS,
    RX_DIR,
    RX_CODE,
    RX_DATA,
    RX_DCS,
    RX_POST
  } rx_phase_t;

  rx_phase_t   phase;
  logic [7:0]  prev_byte;
  logic [7:0]  hdr_sum;
  logic [7:0]  data_sum;
  logic [7:0]  resp_code;
  logic [15:0] frame_len;
  logic [15:0] bytes_left;
  logic [15:0] max_payload;
  out_item_t   expected_results[$];
  out_item_t   want;
  int          mismatches = 0;

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  // builds the end-of-frame status and drops back to hunting
  function automatic out_item_t frame_end(input status_t st);
    out_item_t r;
    r.kind           = KIND_STATUS;
    r.payload_byte   = 8'h00;
    r.status         = st;
    r.response_code  = (st == ST_OK) ? resp_code : 8'h00;
    r.payload_length = (st == ST_OK) ? frame_len - MIN_FRAME_LENGTH : 16'h0000;
    r.is_last        = 1'b1;
    phase     = RX_HUNT;
    prev_byte = START_HI;
    return r;
  endfunction

  task automatic parse_item(input in_item_t it);
    logic [7:0] b;
    logic [7:0] sum;
    out_item_t  r;
    b = it.rx_byte;
    if (it.cmd == CMD_TIMEOUT) begin
      expected_results.push_back(frame_end(ST_TIMEOUT));
      return;
    end
    case (phase)
      RX_HUNT: begin
        if (prev_byte == START_LO && b == START_HI) begin
          prev_byte = START_HI;
          resp_code = 8'h00;
          phase     = RX_LEN;
        end else begin
          prev_byte = b;
        end
      end
      RX_LEN: begin
        hdr_sum = b;
        phase   = RX_LCS;
      end
      RX_LCS: begin
        sum = hdr_sum + b;
        // FF FF marks the extended length form
        if (hdr_sum == 8'hFF && b == 8'hFF) begin
          phase = RX_EXT_HI;
        end else if (sum != 8'h00) begin
          expected_results.push_back(frame_end(ST_BAD_LCS));
        end else begin
          frame_len = {8'h00, hdr_sum};
          phase     = RX_DIR;
        end
      end
      RX_EXT_HI: begin
        hdr_sum   = b;
        frame_len = {b, 8'h00};
        phase     = RX_EXT_LO;
      end
      RX_EXT_LO: begin
        hdr_sum        = hdr_sum + b;
        frame_len[7:0] = b;
        phase          = RX_EXT_LCS;
      end
      RX_EXT_LCS: begin
        sum = hdr_sum + b;
        if (sum != 8'h00) begin
          expected_results.push_back(frame_end(ST_BAD_LCS));
        end else begin
          phase = RX_DIR;
        end
      end
      RX_DIR: begin
        if (b != DIR_BYTE) begin
          expected_results.push_back(frame_end(ST_BAD_DIR));
        end else begin
          phase = RX_CODE;
        end
      end
      RX_CODE: begin
        resp_code = b;
        data_sum  = DIR_BYTE + b;
        if (frame_len < MIN_FRAME_LENGTH) begin
          expected_results.push_back(frame_end(ST_SHORT_LENGTH));
        end else if (frame_len - MIN_FRAME_LENGTH > max_payload) begin
          expected_results.push_back(frame_end(ST_OVER_LENGTH));
        end else begin
          bytes_left = frame_len - MIN_FRAME_LENGTH;
          phase      = (bytes_left != 16'h0000) ? RX_DATA : RX_DCS;
        end
      end
      RX_DATA: begin
        data_sum   = data_sum + b;
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'h0000) begin
          phase = RX_DCS;
        end
        r.kind           = KIND_DATA;
        r.payload_byte   = b;
        r.status         = ST_OK;
        r.response_code  = resp_code;
        r.payload_length = frame_len - MIN_FRAME_LENGTH;
        r.is_last        = 1'b0;
        expected_results.push_back(r);
      end
      RX_DCS: begin
        data_sum = data_sum + b;
        phase    = RX_POST;
      end
      RX_POST: begin
        // checksum error wins over a bad postamble
        if (data_sum != 8'h00) begin
          expected_results.push_back(frame_end(ST_BAD_DCS));
        end else if (b != 8'h00) begin
          expected_results.push_back(frame_end(ST_BAD_POST));
        end else begin
          expected_results.push_back(frame_end(ST_OK));
        end
      end
      default: begin
        phase     = RX_HUNT;
        prev_byte = START_HI;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase       = RX_HUNT;
      prev_byte   = START_HI;
      hdr_sum     = 8'h00;
      data_sum    = 8'h00;
      resp_code   = 8'h00;
      frame_len   = 16'h0000;
      bytes_left  = 16'h0000;
      max_payload = MAX_PAYLOAD_RST;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: kind=%0d byte=%02h st=%0d code=%02h len=%0d last=%0d",
                   $time, out_item.kind, out_item.payload_byte, out_item.status,
                   out_item.response_code, out_item.payload_length, out_item.is_last);
        end else begin
          want = expected_results.pop_front();
          if (out_item.kind !== want.kind || out_item.payload_byte !== want.payload_byte ||
              out_item.status !== want.status ||
              out_item.response_code !== want.response_code ||
              out_item.payload_length !== want.payload_length ||
              out_item.is_last !== want.is_last) begin
            mismatches++;
            $display("%0t: mismatch expected kind=%0d byte=%02h st=%0d code=%02h len=%0d last=%0d",
                     $time, want.kind, want.payload_byte, want.status, want.response_code,
                     want.payload_length, want.is_last);
            $display("%0t:          actual   kind=%0d byte=%02h st=%0d code=%02h len=%0d last=%0d",
                     $time, out_item.kind, out_item.payload_byte, out_item.status,
                     out_item.response_code, out_item.payload_length, out_item.is_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        max_payload = cfg_data;
      end
      if (in_valid && in_ready) begin
        parse_item(in_item);
      end
    end
    error_count   <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

/* bench/nfc_frame_deframer_unit_tb.sv */
// testbench top for the nfc frame deframer: frame stimulus, payload limit phases and verdict
`timescale 1ns / 1ps
module nfc_frame_deframer_unit_tb;
  import nfd_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int SETTLE_CYCLES   = 6;
  localparam int NUM_PHASES      = 7;

  typedef enum logic [2:0] {
    FLT_NONE,
    FLT_LCS,
    FLT_DIR,
    FLT_SHORT,
    FLT_OVER,
    FLT_DCS,
    FLT_POST,
    FLT_CUT
  } frame_fault_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_item   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data  = 16'h0000;
  logic        in_ready;
  logic        out_valid;
  logic        cfg_ready;
  out_item_t   out_item;
  int          error_count;
  int          pending_count;
  int          cycles      = 0;
  int          items_sent  = 0;
  logic        calm        = 1'b0;
  logic [15:0] max_setting = MAX_PAYLOAD_RST;
  logic [15:0] phase_max [NUM_PHASES] = '{16'd255, 16'd0, 16'd65533, 16'd1, 16'd65532,
                                          16'd20, 16'd255};
  in_item_t    frame_q[$];

  nfc_frame_deframer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  nfd_frame_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic in_item_t rx(input logic [7:0] b);
    in_item_t it;
    it.cmd     = CMD_BYTE;
    it.rx_byte = b;
    return it;
  endfunction

  function automatic in_item_t timeout_item();
    in_item_t it;
    it.cmd     = CMD_TIMEOUT;
    it.rx_byte = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic send_frames();
    while (frame_q.size() != 0) send_item(frame_q.pop_front());
  endtask

  // stop sending and wait until every predicted result is out and the pipe is empty
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    max_setting = v;
  endtask

  task automatic build_frame(input int unsigned plen, input frame_fault_t flt, input logic ext);
    logic [15:0] flen;
    logic [7:0]  lcs;
    logic [7:0]  code;
    logic [7:0]  dsum;
    logic [7:0]  b;
    int unsigned n_data;
    int unsigned first;
    int unsigned cut_at;
    first = frame_q.size();
    flen  = 16'(plen + 2);
    if (flt == FLT_SHORT) flen = 16'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) frame_q.push_back(rx(START_LO));
    frame_q.push_back(rx(START_LO));
    frame_q.push_back(rx(START_HI));
    if (ext || flen > 16'd255) begin
      frame_q.push_back(rx(8'hFF));
      frame_q.push_back(rx(8'hFF));
      frame_q.push_back(rx(flen[15:8]));
      frame_q.push_back(rx(flen[7:0]));
      lcs = -(flen[15:8] + flen[7:0]);
    end else begin
      frame_q.push_back(rx(flen[7:0]));
      lcs = -flen[7:0];
    end
    if (flt == FLT_LCS) begin
      frame_q.push_back(rx(lcs + 8'($urandom_range(1, 255))));
      return;
    end
    frame_q.push_back(rx(lcs));
    if (flt == FLT_DIR) begin
      do b = 8'($urandom); while (b == DIR_BYTE);
      frame_q.push_back(rx(b));
      return;
    end
    frame_q.push_back(rx(DIR_BYTE));
    code = 8'($urandom);
    frame_q.push_back(rx(code));
    if (flt == FLT_SHORT || flt == FLT_OVER) return;
    dsum = DIR_BYTE + code;
    // very long payloads are abandoned with a timeout after a few bytes
    n_data = (plen > 48) ? $urandom_range(1, 8) : plen;
    for (int i = 0; i < n_data; i++) begin
      b    = 8'($urandom);
      dsum = dsum + b;
      frame_q.push_back(rx(b));
    end
    if (n_data < plen) begin
      frame_q.push_back(timeout_item());
      return;
    end
    b = -dsum;
    if (flt == FLT_DCS) b = b + 8'($urandom_range(1, 255));
    frame_q.push_back(rx(b));
    frame_q.push_back(rx((flt == FLT_POST) ? 8'($urandom_range(1, 255)) : 8'h00));
    if (flt == FLT_CUT) begin
      cut_at = $urandom_range(first + 2, frame_q.size() - 1);
      while (frame_q.size() > cut_at) void'(frame_q.pop_back());
      frame_q.push_back(timeout_item());
    end
  endtask

  task automatic random_frame();
    int unsigned  r;
    int unsigned  plen;
    frame_fault_t flt;
    logic         ext;
    r   = $urandom_range(0, 99);
    flt = (r < 55) ? FLT_NONE  : (r < 62) ? FLT_LCS  : (r < 69) ? FLT_DIR :
          (r < 75) ? FLT_SHORT : (r < 81) ? FLT_OVER : (r < 87) ? FLT_DCS :
          (r < 93) ? FLT_POST  : FLT_CUT;
    if (flt == FLT_OVER && max_setting >= 16'd65533) flt = FLT_NONE;
    ext = ($urandom_range(0, 3) == 0);
    if (flt == FLT_OVER) begin
      plen = max_setting + 1;
    end else if ($urandom_range(0, 19) == 0) begin
      plen = max_setting;
    end else begin
      plen = $urandom_range(0, (max_setting < 16'd12) ? max_setting : 12);
    end
    // line noise and stray timeouts between frames
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) frame_q.push_back(rx(8'($urandom)));
    end
    if ($urandom_range(0, 24) == 0) frame_q.push_back(timeout_item());
    build_frame(plen, flt, ext);
  endtask

  initial begin
    int phase_start;
    phase_max[5] = 16'($urandom_range(2, 40));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // timeout while hunting, a one-byte frame, an empty extended frame
    frame_q.push_back(timeout_item());
    frame_q.push_back(rx(START_LO));
    frame_q.push_back(rx(START_HI));
    frame_q.push_back(rx(8'h03));
    frame_q.push_back(rx(8'hFD));
    frame_q.push_back(rx(DIR_BYTE));
    frame_q.push_back(rx(8'h00));
    frame_q.push_back(rx(8'hFF));
    frame_q.push_back(rx(8'h2C));
    frame_q.push_back(rx(8'h00));
    frame_q.push_back(rx(START_LO));
    frame_q.push_back(rx(START_HI));
    frame_q.push_back(rx(8'hFF));
    frame_q.push_back(rx(8'hFF));
    frame_q.push_back(rx(8'h00));
    frame_q.push_back(rx(8'h02));
    frame_q.push_back(rx(8'hFE));
    frame_q.push_back(rx(DIR_BYTE));
    frame_q.push_back(rx(8'hFF));
    frame_q.push_back(rx(8'h2C));
    frame_q.push_back(rx(8'h00));
    send_frames();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        write_max_payload(phase_max[p]);
        calm <= (p == 3);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        random_frame();
        send_frames();
      end
    end

    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/nfd_pkg.sv
hw/rtl/nfd_in_reg.sv
hw/rtl/nfd_core.sv
hw/rtl/nfd_out_reg.sv
hw/rtl/nfc_frame_deframer_unit.sv
hw/rtl/nfd_checker.sv
bench/nfd_frame_checker.sv
bench/nfc_frame_deframer_unit_tb.sv
